### rtl/core/vdi_pkg.sv
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared sizes, codes, controller/datapath bundles and the slot hash for the
// vertex deduplication indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  // Capacity of the vertex store and limit of the triangle counter.
  localparam int MAX_VERTICES  = 1024;
  localparam int MAX_TRIANGLES = 4096;

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int VCNT_W = VIDX_W + 1;
  localparam int TIDX_W = $clog2(MAX_TRIANGLES);
  localparam int TCNT_W = TIDX_W + 1;

  // The hash table holds twice as many slots as vertices, so a probe
  // sequence always ends on an empty slot.
  localparam int SLOTS  = 2 * MAX_VERTICES;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int KEY_W    = 96;
  localparam int CORNER_W = 2;
  localparam int STATUS_W = 2;
  localparam int ENTRY_W  = 1 + KEY_W + VIDX_W;

  localparam int IN_W  = ((KEY_W + CORNER_W + 7) / 8) * 8;
  localparam int OUT_W = ((VIDX_W + STATUS_W + TIDX_W + 7) / 8) * 8;

  typedef logic [CORNER_W-1:0] corner_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam corner_t CORNER_CLOSE = 2'd2;

  localparam status_t ST_EXISTING = 2'd0;
  localparam status_t ST_NEW      = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_TRILIMIT = 2'd3;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_CMP    = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic take;
    logic set_limit;
    logic probe_next;
    logic insert;
    logic found;
    logic emit;
  } vdi_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic tri_limit;
    logic slot_valid;
    logic key_match;
    logic out_free;
  } vdi_stat_t;

  // XOR fold of the 96-bit position onto a slot address.
  function automatic logic [SLOT_W-1:0] key_hash(input logic [KEY_W-1:0] key);
    logic [SLOT_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % SLOT_W] = h[i % SLOT_W] ^ key[i];
    end
    return h;
  endfunction

endpackage

### rtl/core/vdi_ram.sv
// ----------------------------------------------------------------------------
// vdi_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vdi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/vdi_ctrl.sv
// ----------------------------------------------------------------------------
// vdi_ctrl
// Controller: clearing pass, input acceptance, probe loop and result hand-off.
// ----------------------------------------------------------------------------
module vdi_ctrl
  import vdi_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  vdi_stat_t stat,
  output vdi_cmd_t  cmd
);

  state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.take = 1'b1;
          if (stat.tri_limit) begin
            cmd.set_limit = 1'b1;
            state_next    = S_RESULT;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (!stat.slot_valid) begin
          cmd.insert = 1'b1;
          state_next = S_RESULT;
        end else if (stat.key_match) begin
          cmd.found  = 1'b1;
          state_next = S_RESULT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_READ;
        end
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

### rtl/core/vdi_dpath.sv
// ----------------------------------------------------------------------------
// vdi_dpath
// Datapath: key register, hash probe address, slot table, counters and the
// output register.
// ----------------------------------------------------------------------------
module vdi_dpath
  import vdi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,
  input  vdi_cmd_t         cmd,
  output vdi_stat_t        stat
);

  logic [KEY_W-1:0]   key_r;
  corner_t            corner_r;
  logic [SLOT_W-1:0]  probe_addr;
  logic [SLOT_W-1:0]  clr_addr;
  logic [VCNT_W-1:0]  vcount;
  logic [TCNT_W-1:0]  tcount;
  logic [VIDX_W-1:0]  res_vidx;
  status_t            res_status;
  logic [TIDX_W-1:0]  res_tidx;

  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               has_room;
  logic               closes;

  assign has_room = (vcount < VCNT_W'(MAX_VERTICES));
  assign closes   = (corner_r == CORNER_CLOSE);

  // Status back to the controller.
  assign stat.clr_last   = (clr_addr == SLOT_W'(SLOTS - 1));
  assign stat.tri_limit  = (tcount >= TCNT_W'(MAX_TRIANGLES));
  assign stat.slot_valid = ram_rdata[ENTRY_W-1];
  assign stat.key_match  = (ram_rdata[KEY_W+VIDX_W-1:VIDX_W] == key_r);
  assign stat.out_free   = !m_tvalid || m_tready;

  // Slot table write: clearing sweep or insertion of a new vertex.
  always_comb begin
    ram_we    = cmd.clr_step || (cmd.insert && has_room);
    ram_waddr = cmd.clr_step ? clr_addr : probe_addr;
    ram_wdata = cmd.clr_step ? '0 : {1'b1, key_r, vcount[VIDX_W-1:0]};
  end

  vdi_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(probe_addr),
    .rdata(ram_rdata)
  );

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      vcount   <= '0;
      tcount   <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.insert && has_room) begin
        vcount <= vcount + 1'b1;
      end
      if ((cmd.insert || cmd.found) && closes) begin
        tcount <= tcount + 1'b1;
      end
    end
  end

  // Input key and probe address.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      key_r      <= s_tdata[KEY_W-1:0];
      corner_r   <= s_tdata[KEY_W+CORNER_W-1:KEY_W];
      probe_addr <= key_hash(s_tdata[KEY_W-1:0]);
    end else if (cmd.probe_next) begin
      probe_addr <= probe_addr + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.set_limit) begin
      res_vidx   <= '0;
      res_status <= ST_TRILIMIT;
      res_tidx   <= '0;
    end else if (cmd.found) begin
      res_vidx   <= ram_rdata[VIDX_W-1:0];
      res_status <= ST_EXISTING;
      res_tidx   <= tcount[TIDX_W-1:0];
    end else if (cmd.insert) begin
      res_vidx   <= has_room ? vcount[VIDX_W-1:0] : '0;
      res_status <= has_room ? ST_NEW : ST_FULL;
      res_tidx   <= tcount[TIDX_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= OUT_W'({res_tidx, res_status, res_vidx});
    end
  end

endmodule

### rtl/core/vertex_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// Assigns vertex indices to triangle corners, merging bit-identical positions.
// ----------------------------------------------------------------------------
// Usage: each transaction on the s_ channel carries one triangle corner
// (x, y, z float bit patterns and the corner number). Each one yields exactly
// one transaction on the m_ channel with the vertex index, a status code and
// the triangle index. Positions are found by hashing into a table of twice
// the vertex capacity and probing linearly, each probe a table read followed
// by a compare. A corner past the triangle limit skips the probe and goes
// straight to the result. One corner is in flight at a time: a new corner is
// accepted only once the last one's result has moved to the output register.
// After reset the table is swept to empty, during which s_tready stays low.
// The output register holds a result while the receiver stalls, and the next
// corner may be accepted and processed meanwhile; its result waits until the
// register is free.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer
  import vdi_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], corner [97:96], zero fill
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // vertex_index [9:0], status [11:10], triangle_index [23:12]
  output logic [OUT_W-1:0] m_tdata
);

  vdi_cmd_t  cmd;
  vdi_stat_t stat;

  vdi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  vdi_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

### rtl/core/vdi_checker.sv
// ----------------------------------------------------------------------------
// vdi_checker
// Port-level checks for the vertex deduplication indexer.
// ----------------------------------------------------------------------------
module vdi_checker
  import vdi_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) $past(rst) |-> !m_tvalid && !s_tready)
    else $error("activity right after reset");

  // A triangle-limit result carries zero indices.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:10] == ST_TRILIMIT) |->
      (m_tdata[9:0] == '0) && (m_tdata[23:12] == '0))
    else $error("limit result with nonzero index");

  // A store-full result carries vertex index zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[11:10] == ST_FULL) |-> (m_tdata[9:0] == '0))
    else $error("full result with nonzero vertex index");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vertex_dedup_indexer. Corners are sent over the
// slave stream with random idle gaps, and every result on the master stream
// is compared field by field with a local model of the vertex store and the
// triangle counter. The run covers repeated and fresh positions, store
// overflow and a long run of closed triangles.
// ----------------------------------------------------------------------------
module testbench;
  import vdi_pkg::*;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  // pos_x [31:0], pos_y [63:32], pos_z [95:64], corner [97:96], zero fill
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  // vertex_index [9:0], status [11:10], triangle_index [23:12]
  logic [OUT_W-1:0] m_tdata;

  typedef struct packed {
    logic [VIDX_W-1:0] vidx;
    status_t           status;
    logic [TIDX_W-1:0] tidx;
  } corner_result_t;

  // Local copy of the vertex store and counters.
  logic [KEY_W-1:0] stored_pos [MAX_VERTICES];
  int unsigned      stored_count;
  int unsigned      closed_tris;
  corner_result_t   pending_results [$];
  logic [KEY_W-1:0] recent_pos [$];

  int     send_idle_pct;
  int     recv_idle_pct;
  int     mismatches;
  int     result_count;
  longint cycle_count;
  int     full_seen;
  int     limit_seen;

  vertex_dedup_indexer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Predict the result of one corner and update the local store.
  function automatic corner_result_t index_corner(input logic [KEY_W-1:0] pos,
                                                  input corner_t corner);
    corner_result_t r;
    bit hit;
    r = '0;
    hit = 1'b0;
    if (closed_tris >= MAX_TRIANGLES) begin
      r.status = ST_TRILIMIT;
      return r;
    end
    r.tidx = closed_tris[TIDX_W-1:0];
    for (int i = 0; i < stored_count; i++) begin
      if (!hit && stored_pos[i] == pos) begin
        hit = 1'b1;
        r.vidx = i[VIDX_W-1:0];
      end
    end
    if (hit) begin
      r.status = ST_EXISTING;
    end else if (stored_count < MAX_VERTICES) begin
      stored_pos[stored_count] = pos;
      r.vidx = stored_count[VIDX_W-1:0];
      r.status = ST_NEW;
      stored_count++;
    end else begin
      r.status = ST_FULL;
    end
    if (corner == CORNER_CLOSE) closed_tris++;
    return r;
  endfunction

  // Send one corner; the expectation is queued at the accepting edge.
  // The valid line drops only during idle cycles, so a corner can follow
  // directly on the previous one.
  task automatic send_corner(input logic [KEY_W-1:0] pos, input corner_t corner);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-KEY_W-CORNER_W){1'b0}}, corner, pos};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(index_corner(pos, corner));
    recent_pos.push_back(pos);
    if (recent_pos.size() > 64) void'(recent_pos.pop_front());
    @(negedge clk);
  endtask

  // Receiver stalls and result checking.
  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    corner_result_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[VIDX_W-1:0], m_tdata[VIDX_W+STATUS_W-1:VIDX_W],
             m_tdata[VIDX_W+STATUS_W+TIDX_W-1:VIDX_W+STATUS_W]};
      result_count++;
      if (got.status == ST_FULL) full_seen++;
      if (got.status == ST_TRILIMIT) limit_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result vidx=%0d status=%0d tidx=%0d",
                                       got.vidx, got.status, got.tidx);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected vidx=%0d status=%0d tidx=%0d, got %0d %0d %0d",
                     want.vidx, want.status, want.tidx, got.vidx, got.status, got.tidx);
        end
      end
    end
  end

  // Timeout.
  always @(posedge clk) begin
    if (cycle_count > 400000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [KEY_W-1:0] rand_pos();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Random position: mostly a recent one, else fresh or from a tiny grid.
  function automatic logic [KEY_W-1:0] mesh_pos();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55 && recent_pos.size() > 0)
      return recent_pos[$urandom_range(recent_pos.size() - 1)];
    if (pick < 70)
      return {30'd0, 2'($urandom), 30'd0, 2'($urandom), 30'd0, 2'($urandom)};
    return rand_pos();
  endfunction

  // Field extremes, signed zeros, NaN patterns and every corner code.
  task automatic test_directed();
    send_corner('0, 2'd0);
    send_corner({32'h0, 32'h0, 32'h8000_0000}, 2'd1);
    send_corner('1, 2'd3);
    send_corner('0, CORNER_CLOSE);
    send_corner({32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0000}, 2'd0);
    send_corner({32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0001}, 2'd1);
    send_corner({32'h7fc0_0000, 32'h7fc0_0000, 32'h7fc0_0000}, CORNER_CLOSE);
    send_corner({32'hffff_ffff, 32'h0, 32'hffff_ffff}, 2'd3);
    send_corner({32'h0, 32'hffff_ffff, 32'h0}, 2'd0);
    send_corner('1, CORNER_CLOSE);
  endtask

  // Well-formed triangles with shared corners, plus some stray corner codes.
  task automatic test_mesh(input int corners);
    corner_t c;
    for (int i = 0; i < corners; i++) begin
      c = corner_t'(i % 3);
      if ($urandom_range(99) < 8) c = corner_t'($urandom_range(3));
      send_corner(mesh_pos(), c);
    end
  endtask

  // Fill the vertex store past capacity with fresh positions.
  task automatic test_store_full();
    while (stored_count < MAX_VERTICES + 20) begin
      send_corner(rand_pos(), corner_t'(stored_count % 3 == 2 ? 0 : 1));
      if (stored_count >= MAX_VERTICES) break;
    end
    for (int i = 0; i < 40; i++) send_corner(i % 2 ? rand_pos() : mesh_pos(), 2'd1);
  endtask

  // A run of closing corners on a full store, then stray corner codes.
  task automatic test_triangle_run();
    for (int i = 0; i < 230; i++)
      send_corner($urandom_range(1) ? mesh_pos() : rand_pos(), CORNER_CLOSE);
    for (int i = 0; i < 20; i++) send_corner(mesh_pos(), corner_t'($urandom_range(3)));
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    stored_count = 0;
    closed_tris = 0;
    mismatches = 0;
    result_count = 0;
    cycle_count = 0;
    full_seen = 0;
    limit_seen = 0;
    send_idle_pct = 9;
    recv_idle_pct = 53;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_mesh(600);
    send_idle_pct = 53;
    recv_idle_pct = 9;
    test_mesh(400);
    test_store_full();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_triangle_run();
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    $display("Checked %0d results: %0d vertices stored, %0d triangles closed,",
             result_count, stored_count, closed_tris);
    $display("%0d store-full and %0d triangle-limit answers.", full_seen, limit_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/vdi_pkg.sv
rtl/core/vdi_ram.sv
rtl/core/vdi_ctrl.sv
rtl/core/vdi_dpath.sv
rtl/core/vertex_dedup_indexer.sv
rtl/core/vdi_checker.sv
sim/testbench.sv
